>>> rtl/imufp_pkg.sv
// Shared constants, codes and types of the IMU frame parser.
package imufp_pkg;

   localparam int BYTE_W     = 8;
   localparam int GAIN_W     = 16;
   localparam int WORD_W     = 16;
   localparam int VALUE_W    = 33;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 4;
   localparam int N_AXES     = 3;
   localparam int N_DATA     = 2 * N_AXES;
   localparam int DATA_IDX_W = $clog2(N_DATA);

   // frame layout: header, type, six data bytes, two spare bytes, checksum
   localparam logic [POS_W-1:0] POS_TYPE       = POS_W'(1);
   localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(2);
   localparam logic [POS_W-1:0] POS_DATA_LAST  = POS_W'(7);
   localparam logic [POS_W-1:0] POS_CHECKSUM   = POS_W'(10);

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEL   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ANGLE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_CHKERR  = 2'd3;

   // configuration register map (word index)
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_TYPE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_TYPE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_GAIN = 3'd4;

   // register reset values
   localparam logic [BYTE_W-1:0] RST_HEADER     = 8'h55;
   localparam logic [BYTE_W-1:0] RST_ACCEL_TYPE = 8'h51;
   localparam logic [BYTE_W-1:0] RST_ANGLE_TYPE = 8'h53;
   localparam logic [GAIN_W-1:0] RST_ACCEL_GAIN = 16'd40141;
   localparam logic [GAIN_W-1:0] RST_ANGLE_GAIN = 16'd46080;

   typedef logic [BYTE_W-1:0]          byte_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic signed [VALUE_W-1:0]  value_type;

endpackage

>>> rtl/imufp_req_if.sv
// Byte input channel of the IMU frame parser.
interface imufp_req_if
   import imufp_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/imufp_rsp_if.sv
// Result channel of the IMU frame parser.
interface imufp_rsp_if
   import imufp_pkg::*;
   ();
   logic       valid;
   logic       ready;
   status_type frame_status;
   value_type  value_x;
   value_type  value_y;
   value_type  value_z;

   modport source (output valid, output frame_status, output value_x, output value_y,
                   output value_z, input ready);
   modport sink   (input valid, input frame_status, input value_x, input value_y,
                   input value_z, output ready);
endinterface

>>> rtl/imu_frame_parser.sv
// Top level of the IMU frame parser: byte hunt, running checksum and scaling.
// Path: a byte is registered on transfer in the input register; the checksum byte's result
//   is loaded into the result register once that register is free, and offered from there.
// Throughput: one byte per cycle; set by the single parse stage, which also holds the three
//   17 x 17 multipliers used only on the checksum byte. A checksum byte waits in the input
//   register only while the result register is full and its result is not taken.
// Reset (synchronous, active high): hunt for header, clear sum, empty both stages
//   and load the configuration registers with their default values.
module imu_frame_parser
   import imufp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   imufp_req_if.sink             req_if,
   imufp_rsp_if.source           rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   byte_type          header_ff, header_in;
   byte_type          accel_type_ff, accel_type_in;
   byte_type          angle_type_ff, angle_type_in;
   logic [GAIN_W-1:0] accel_gain_ff, accel_gain_in;
   logic [GAIN_W-1:0] angle_gain_ff, angle_gain_in;

   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      header_in     = header_ff;
      accel_type_in = accel_type_ff;
      angle_type_in = angle_type_ff;
      accel_gain_in = accel_gain_ff;
      angle_gain_in = angle_gain_ff;
      if (csr_write) begin
         // drop writes to addresses beyond the register map
         unique case (csr_idx)
            REG_HEADER:     header_in     = csr_pwdata[BYTE_W-1:0];
            REG_ACCEL_TYPE: accel_type_in = csr_pwdata[BYTE_W-1:0];
            REG_ANGLE_TYPE: angle_type_in = csr_pwdata[BYTE_W-1:0];
            REG_ACCEL_GAIN: accel_gain_in = csr_pwdata[GAIN_W-1:0];
            REG_ANGLE_GAIN: angle_gain_in = csr_pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_HEADER:     csr_prdata = CSR_DATA_W'(header_ff);
         REG_ACCEL_TYPE: csr_prdata = CSR_DATA_W'(accel_type_ff);
         REG_ANGLE_TYPE: csr_prdata = CSR_DATA_W'(angle_type_ff);
         REG_ACCEL_GAIN: csr_prdata = CSR_DATA_W'(accel_gain_ff);
         REG_ANGLE_GAIN: csr_prdata = CSR_DATA_W'(angle_gain_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff     <= RST_HEADER;
         accel_type_ff <= RST_ACCEL_TYPE;
         angle_type_ff <= RST_ANGLE_TYPE;
         accel_gain_ff <= RST_ACCEL_GAIN;
         angle_gain_ff <= RST_ANGLE_GAIN;
      end else begin
         header_ff     <= header_in;
         accel_type_ff <= accel_type_in;
         angle_type_ff <= angle_type_in;
         accel_gain_ff <= accel_gain_in;
         angle_gain_ff <= angle_gain_in;
      end
   end

   // ---------------------------------------------------------------
   // Input register: hold one transferred byte for the parse stage
   // ---------------------------------------------------------------
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff;
   logic     in_frame_ff, in_frame_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   byte_type sum_ff, sum_in;

   logic closing;     // byte in the input register is the checksum byte
   logic out_free;    // result register can take a new result this cycle
   logic s1_take;     // parse stage consumes the byte in the input register
   logic req_xfer;

   assign closing  = in_frame_ff && (pos_ff == POS_CHECKSUM);
   assign out_free = !rsp_if.valid || rsp_if.ready;
   // only the checksum byte ever waits for the result register
   assign s1_take  = in_valid_ff && (!closing || out_free);
   assign req_if.ready = !in_valid_ff || s1_take;
   assign req_xfer = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (s1_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   // ---------------------------------------------------------------
   // Parse stage: hunt, position count, running checksum, byte capture
   // ---------------------------------------------------------------
   byte_type frame_type_ff;
   byte_type data_ff [N_DATA];
   logic     data_wr;
   logic [DATA_IDX_W-1:0] data_idx;
   logic [POS_W-1:0]      data_off;

   assign data_off = pos_ff - POS_DATA_FIRST;
   assign data_idx = data_off[DATA_IDX_W-1:0];
   assign data_wr  = s1_take && in_frame_ff
                     && (pos_ff >= POS_DATA_FIRST) && (pos_ff <= POS_DATA_LAST);

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      if (s1_take) begin
         if (!in_frame_ff) begin
            // ignore everything but the header while hunting
            if (in_byte_ff == header_ff) begin
               in_frame_in = 1'b1;
               sum_in      = in_byte_ff;
               pos_in      = POS_TYPE;
            end
         end else if (!closing) begin
            // a header byte inside a frame is ordinary data
            sum_in = sum_ff + in_byte_ff;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            in_frame_in = 1'b0;
            pos_in      = '0;
            sum_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         sum_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take && in_frame_ff && (pos_ff == POS_TYPE)) begin
         frame_type_ff <= in_byte_ff;
      end
      if (data_wr) begin
         data_ff[data_idx] <= in_byte_ff;
      end
   end

   // ---------------------------------------------------------------
   // Frame decode and scaling on the checksum byte
   // ---------------------------------------------------------------
   status_type status_cmb;
   logic signed [GAIN_W:0]     gain_op;
   logic signed [WORD_W:0]     word_op [N_AXES];
   logic signed [GAIN_W+WORD_W+1:0] prod [N_AXES];
   logic [WORD_W-1:0]          word [N_AXES];

   always_comb begin
      // a bad checksum wins; on equal type codes the frame counts as acceleration
      priority if (sum_ff != in_byte_ff) begin
         status_cmb = STATUS_CHKERR;
      end else if (frame_type_ff == accel_type_ff) begin
         status_cmb = STATUS_ACCEL;
      end else if (frame_type_ff == angle_type_ff) begin
         status_cmb = STATUS_ANGLE;
      end else begin
         status_cmb = STATUS_UNKNOWN;
      end
   end

   assign gain_op = (status_cmb == STATUS_ACCEL) ? $signed({1'b0, accel_gain_ff})
                                                 : $signed({1'b0, angle_gain_ff});

   always_comb begin
      for (int k = 0; k < N_AXES; k++) begin
         // little-endian words: low byte first
         word[k] = {data_ff[2*k+1], data_ff[2*k]};
         unique case (status_cmb)
            STATUS_ACCEL: word_op[k] = $signed({word[k][WORD_W-1], word[k]});
            STATUS_ANGLE: word_op[k] = $signed({1'b0, word[k]});
            default:      word_op[k] = '0;
         endcase
         prod[k] = word_op[k] * gain_op;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   value_type  rsp_value_ff [N_AXES];
   logic       rsp_load;

   assign rsp_load = s1_take && closing;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_cmb;
         for (int k = 0; k < N_AXES; k++) begin
            rsp_value_ff[k] <= prod[k][VALUE_W-1:0];
         end
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.frame_status = rsp_status_ff;
   assign rsp_if.value_x      = rsp_value_ff[0];
   assign rsp_if.value_y      = rsp_value_ff[1];
   assign rsp_if.value_z      = rsp_value_ff[2];

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // position is zero while hunting and never passes the checksum byte
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (!in_frame_ff |-> pos_ff == '0) and (in_frame_ff |-> pos_ff <= POS_CHECKSUM))
      else $error("byte position out of range");

   // a new result comes only from a checksum byte in the parse stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_if.ready))
      |-> $past(in_valid_ff && closing))
      else $error("result without checksum byte");

   // status-only frames carry zero values
   a_zero_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_UNKNOWN || rsp_status_ff == STATUS_CHKERR))
      |-> (rsp_value_ff[0] == '0 && rsp_value_ff[1] == '0 && rsp_value_ff[2] == '0))
      else $error("status-only result with non-zero value");

   // the input side stalls only behind a checksum byte waiting for the result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (in_valid_ff && closing && rsp_valid_ff && !rsp_if.ready))
      else $error("unexpected input stall");

endmodule
